// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the multiplier checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define BSM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion, checked during reset as well.
`define BSM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bsm_pkg.sv =====
// ---------------------------------------------------------------------------
// bsm_pkg
// Widths, Booth pair codes and stage state type for the Booth multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_WIDTH   = 32;
    localparam int PRODUCT_WIDTH = 64;
    localparam int ACC_WIDTH     = OPERAND_WIDTH + 1;
    localparam int NUM_STAGES    = OPERAND_WIDTH;

    // {current multiplier bit, bit below}
    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

    typedef struct packed {
        logic [ACC_WIDTH-1:0]     acc;
        logic [OPERAND_WIDTH-1:0] q;
        logic                     below;
        logic [ACC_WIDTH-1:0]     m;
    } t_booth_state;

endpackage

`default_nettype wire

// ===== design/bsm_stage.sv =====
// ---------------------------------------------------------------------------
// bsm_stage
// One radix-2 Booth step: add, subtract or pass, arithmetic shift, then register.
// ---------------------------------------------------------------------------
`default_nettype none

module bsm_stage (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_valid,
    input  bsm_pkg::t_booth_state i_state,
    output logic                  o_valid,
    output bsm_pkg::t_booth_state o_state
);
    import bsm_pkg::*;

    logic                 r_valid;
    t_booth_state         r_state;
    t_booth_state         n_state;
    logic [ACC_WIDTH-1:0] w_sum;

    always_comb begin
        case ({i_state.q[0], i_state.below})
            BOOTH_SUB: w_sum = i_state.acc - i_state.m;
            BOOTH_ADD: w_sum = i_state.acc + i_state.m;
            default:   w_sum = i_state.acc;
        endcase
        n_state.acc   = {w_sum[ACC_WIDTH-1], w_sum[ACC_WIDTH-1:1]};
        n_state.q     = {w_sum[0], i_state.q[OPERAND_WIDTH-1:1]};
        n_state.below = i_state.q[0];
        n_state.m     = i_state.m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

`default_nettype wire

// ===== design/booth_signed_multiplier.sv =====
// ---------------------------------------------------------------------------
// booth_signed_multiplier
// Signed radix-2 Booth multiplier, one Booth step per pipeline stage.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_multiplicand, i_multiplier
// output    out        o_valid / i_stall   o_product
//
// One operand pair enters per cycle while the output is not stalled; each pair
// passes through the chain of Booth step registers, each holding one 33-bit add.
// The last stage register is the output register.
// Reset clears the stage valid bits only.
// A stall at the output freezes the whole chain; empty output stages advance.
// ---------------------------------------------------------------------------
`default_nettype none

module booth_signed_multiplier (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire  signed [bsm_pkg::FIELD_WIDTH-1:0]   i_multiplicand,
    input  wire  signed [bsm_pkg::FIELD_WIDTH-1:0]   i_multiplier,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic signed [bsm_pkg::PRODUCT_WIDTH-1:0] o_product
);
    import bsm_pkg::*;

    t_booth_state                     w_state [0:NUM_STAGES];
    logic                             w_valid [0:NUM_STAGES];
    logic                             w_adv;
    logic signed [2*OPERAND_WIDTH-1:0] w_prod;

    assign w_adv   = !w_valid[NUM_STAGES] || !i_stall;
    assign o_stall = !w_adv;

    assign w_valid[0]       = i_valid;
    assign w_state[0].acc   = '0;
    assign w_state[0].q     = i_multiplier[OPERAND_WIDTH-1:0];
    assign w_state[0].below = 1'b0;
    assign w_state[0].m     = {i_multiplicand[OPERAND_WIDTH-1],
                               i_multiplicand[OPERAND_WIDTH-1:0]};

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        bsm_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[g]),
            .i_state (w_state[g]),
            .o_valid (w_valid[g+1]),
            .o_state (w_state[g+1])
        );
    end

    assign w_prod    = {w_state[NUM_STAGES].acc[OPERAND_WIDTH-1:0],
                        w_state[NUM_STAGES].q};
    assign o_product = PRODUCT_WIDTH'(w_prod);
    assign o_valid   = w_valid[NUM_STAGES];

endmodule

`default_nettype wire

// ===== design/bsm_checker.sv =====
// ---------------------------------------------------------------------------
// bsm_checker
// Port-level checks for the Booth multiplier, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bsm_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_valid,
    input wire                                  o_stall,
    input wire [bsm_pkg::FIELD_WIDTH-1:0]       i_multiplicand,
    input wire [bsm_pkg::FIELD_WIDTH-1:0]       i_multiplier,
    input wire                                  o_valid,
    input wire                                  i_stall,
    input wire [bsm_pkg::PRODUCT_WIDTH-1:0]     o_product
);
    import bsm_pkg::*;

    // most negative operand squared, the one product that uses bit 2W-2
    localparam logic [PRODUCT_WIDTH-1:0] PROD_MAX =
        PRODUCT_WIDTH'(1) << (2*OPERAND_WIDTH-2);

    `BSM_ASSERT(a_out_valid_hold, i_clk, i_rst_n,
        (o_valid && i_stall) |=> o_valid,
        "valid dropped under stall")
    `BSM_ASSERT(a_out_data_hold, i_clk, i_rst_n,
        (o_valid && i_stall) |=> $stable(o_product),
        "product changed under stall")
    `BSM_ASSERT(a_stall_cause, i_clk, i_rst_n,
        o_stall |-> (o_valid && i_stall),
        "input stalled without output backpressure")
    `BSM_ASSERT(a_in_hold, i_clk, i_rst_n,
        (i_valid && o_stall) |=> (i_valid && $stable(i_multiplicand) && $stable(i_multiplier)),
        "operands changed under stall")
    `BSM_ASSERT(a_prod_range, i_clk, i_rst_n,
        o_valid |-> ((o_product[PRODUCT_WIDTH-1] == o_product[2*OPERAND_WIDTH-2])
                     || (o_product == PROD_MAX)),
        "product exceeds signed range")

endmodule

bind booth_signed_multiplier bsm_checker u_bsm_checker (.*);

`default_nettype wire
